// ===== rtl/servo_slew_limiter_pwm_unit_defines.svh =====
// Assertion macros shared by the servo slew limiter RTL.
// Each macro clocks on clock and is disabled while reset is high.
// Defining ASSERT_OFF turns every macro into an empty line.
`ifndef SERVO_SLEW_LIMITER_PWM_UNIT_DEFINES_SVH
`define SERVO_SLEW_LIMITER_PWM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define SSL_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`define SSL_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error(msg);

`else

`define SSL_ASSERT_IMPL(label, ante, cons, msg)
`define SSL_ASSERT_NEXT(label, ante, cons, msg)
`define SSL_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== rtl/sslpwm_pkg.sv =====
// Shared types, constants and arithmetic helpers of the servo slew limiter.
// No dependencies; every RTL module of the block uses it by scoped names.
package sslpwm_pkg;

   localparam int NUM_CH      = 2;
   localparam int ANGLE_W     = 11;
   localparam int PULSE_W     = 12;
   localparam int TARGET_W    = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int RSP_DATA_W  = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // x * 10 / 9 for x up to 1024 equals (x * 145640) >> 17.
   localparam logic [17:0] RECIP       = 18'd145640;
   localparam int          RECIP_SHIFT = 17;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic [PULSE_W-1:0]        pulse_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_LIMIT = 2'd0,
      CSR_STEP_LIMIT  = 2'd1,
      CSR_DEADBAND    = 2'd2,
      CSR_CENTER      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  angle_limit;
      logic [9:0]  step_limit;
      logic [7:0]  pulse_deadband;
      logic [10:0] pulse_center;
   } cfg_type;

   typedef struct packed {
      logic      tick;
      logic      channel;
      angle_type target;
   } cmd_type;

   localparam cfg_type CFG_RESET = '{
      angle_limit:    10'd900,
      step_limit:     10'd30,
      pulse_deadband: 8'd3,
      pulse_center:   11'd1500
   };

   localparam pulse_type PULSE_RESET = 12'd1500;

   // Difference from cur to tgt, clamped to plus or minus lim.
   function automatic angle_type step_clamp(angle_type tgt, angle_type cur, logic [9:0] lim);
      logic signed [ANGLE_W:0] diff;
      logic signed [ANGLE_W:0] lim_s;
      logic signed [ANGLE_W:0] res;
      diff  = $signed({tgt[ANGLE_W-1], tgt}) - $signed({cur[ANGLE_W-1], cur});
      lim_s = $signed({2'b00, lim});
      if (diff > lim_s) begin
         res = lim_s;
      end else if (diff < -lim_s) begin
         res = -lim_s;
      end else begin
         res = diff;
      end
      return res[ANGLE_W-1:0];
   endfunction

   // center + angle * 10 / 9 with truncation toward zero, floored at zero and capped at 4095.
   function automatic pulse_type pulse_of(angle_type a, logic [10:0] center);
      logic [ANGLE_W-1:0] mag;
      logic [28:0]        prod;
      logic [10:0]        q;
      logic signed [13:0] q_s;
      logic signed [13:0] us;
      mag  = a[ANGLE_W-1] ? (~a + 11'd1) : a;
      prod = 29'(mag) * 29'(RECIP);
      q    = prod[RECIP_SHIFT +: 11];
      q_s  = $signed({3'b000, q});
      us   = $signed({3'b000, center}) + (a[ANGLE_W-1] ? -q_s : q_s);
      if (us < 14'sd0) begin
         return '0;
      end else if (us > 14'sd4095) begin
         return '1;
      end
      return us[PULSE_W-1:0];
   endfunction

endpackage

// ===== rtl/sslpwm_front.sv =====
// Front end: takes request beats, decodes the action and clamps the target angle.
// Depends on sslpwm_pkg; feeds sslpwm_queue.
module sslpwm_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sslpwm_pkg::TARGET_W-1:0] req_tdata,  // [15:0] target_angle
   input  logic [1:0]                    req_tuser,  // [0] action, [1] channel
   input  logic [9:0]                    angle_limit,
   input  logic                          q_full,
   output logic                          q_push,
   output sslpwm_pkg::cmd_type           q_cmd
);

   logic signed [sslpwm_pkg::TARGET_W:0] req_s;
   logic signed [sslpwm_pkg::TARGET_W:0] lim_s;
   logic signed [sslpwm_pkg::TARGET_W:0] clamped;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      req_s = $signed({req_tdata[sslpwm_pkg::TARGET_W-1], req_tdata});
      lim_s = $signed({7'd0, angle_limit});
      if (req_s > lim_s) begin
         clamped = lim_s;
      end else if (req_s < -lim_s) begin
         clamped = -lim_s;
      end else begin
         clamped = req_s;
      end
   end

   assign q_cmd.tick    = req_tuser[0];
   assign q_cmd.channel = req_tuser[1];
   assign q_cmd.target  = clamped[sslpwm_pkg::ANGLE_W-1:0];

endmodule

// ===== rtl/sslpwm_queue.sv =====
// Two-entry command queue between the front end and the execution back end.
// Depends on sslpwm_pkg and the assertion macro header.
`include "servo_slew_limiter_pwm_unit_defines.svh"

module sslpwm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sslpwm_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output sslpwm_pkg::cmd_type head_cmd
);

   sslpwm_pkg::cmd_type                  mem_ff [sslpwm_pkg::QUEUE_DEPTH];
   logic [sslpwm_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sslpwm_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sslpwm_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == sslpwm_pkg::QUEUE_CNT_W'(sslpwm_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `SSL_ASSERT_NEVER(a_count_in_range, count_ff > 2'd2, "queue count above its depth")
   `SSL_ASSERT_NEXT(a_pop_drains, pop && !push, count_ff == $past(count_ff) - 2'd1, "pop did not drain")

endmodule

// ===== rtl/sslpwm_back.sv =====
// Back end: two-stage execution. Stage one moves the angles, stage two computes
// the pulse widths and holds the result beat. Depends on sslpwm_pkg and the macros.
`include "servo_slew_limiter_pwm_unit_defines.svh"

module sslpwm_back (
   input  logic                               clock,
   input  logic                               reset,
   input  sslpwm_pkg::cfg_type                cfg,
   input  logic                               q_valid,
   input  sslpwm_pkg::cmd_type                q_cmd,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sslpwm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   sslpwm_pkg::angle_type target_ff [sslpwm_pkg::NUM_CH];
   sslpwm_pkg::angle_type target_in [sslpwm_pkg::NUM_CH];
   sslpwm_pkg::angle_type cur_ff    [sslpwm_pkg::NUM_CH];
   sslpwm_pkg::angle_type cur_in    [sslpwm_pkg::NUM_CH];
   sslpwm_pkg::angle_type diff      [sslpwm_pkg::NUM_CH];

   logic                       s1_valid_ff;
   logic                       s1_tick_ff;
   logic [sslpwm_pkg::NUM_CH-1:0] s1_moved_ff, s1_moved_in;

   sslpwm_pkg::pulse_type last_pulse_ff [sslpwm_pkg::NUM_CH];
   sslpwm_pkg::pulse_type last_pulse_in [sslpwm_pkg::NUM_CH];
   sslpwm_pkg::pulse_type new_pulse     [sslpwm_pkg::NUM_CH];
   logic [sslpwm_pkg::PULSE_W-1:0] change [sslpwm_pkg::NUM_CH];
   logic [sslpwm_pkg::NUM_CH-1:0]  wr;

   logic                          out_valid_ff;
   logic                          out_tick_ff;
   logic [sslpwm_pkg::NUM_CH-1:0] out_written_ff;
   sslpwm_pkg::angle_type         out_angle_ff [sslpwm_pkg::NUM_CH];

   logic advance;

   // The whole pipe moves together whenever the result register can take a beat.
   assign advance = !out_valid_ff || rsp_tready;
   assign q_pop   = advance && q_valid;

   // Stage one: target writes and the slew step of each channel.
   always_comb begin
      for (int i = 0; i < sslpwm_pkg::NUM_CH; i++) begin
         diff[i]        = sslpwm_pkg::step_clamp(target_ff[i], cur_ff[i], cfg.step_limit);
         s1_moved_in[i] = (diff[i] != '0);
         cur_in[i]      = (q_pop && q_cmd.tick) ? cur_ff[i] + diff[i] : cur_ff[i];
         target_in[i]   = target_ff[i];
         if (q_pop && !q_cmd.tick && (q_cmd.channel == i[0])) begin
            target_in[i] = q_cmd.target;
         end
      end
   end

   // Stage two: cur_ff already holds the angles left by the item in stage one.
   always_comb begin
      for (int i = 0; i < sslpwm_pkg::NUM_CH; i++) begin
         new_pulse[i] = sslpwm_pkg::pulse_of(cur_ff[i], cfg.pulse_center);
         change[i]    = (new_pulse[i] > last_pulse_ff[i]) ? new_pulse[i] - last_pulse_ff[i]
                                                          : last_pulse_ff[i] - new_pulse[i];
         wr[i]        = s1_valid_ff && s1_tick_ff && s1_moved_ff[i]
                        && (change[i] >= 12'(cfg.pulse_deadband));
         last_pulse_in[i] = wr[i] ? new_pulse[i] : last_pulse_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < sslpwm_pkg::NUM_CH; i++) begin
            target_ff[i]     <= '0;
            cur_ff[i]        <= '0;
            last_pulse_ff[i] <= sslpwm_pkg::PULSE_RESET;
         end
      end else if (advance) begin
         s1_valid_ff  <= q_pop;
         out_valid_ff <= s1_valid_ff;
         for (int i = 0; i < sslpwm_pkg::NUM_CH; i++) begin
            target_ff[i]     <= target_in[i];
            cur_ff[i]        <= cur_in[i];
            last_pulse_ff[i] <= last_pulse_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tick_ff     <= q_cmd.tick;
         s1_moved_ff    <= s1_moved_in;
         out_tick_ff    <= s1_tick_ff;
         out_written_ff <= wr;
         for (int i = 0; i < sslpwm_pkg::NUM_CH; i++) begin
            out_angle_ff[i] <= cur_ff[i];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_angle_ff[1], out_angle_ff[0], out_written_ff[1], out_written_ff[0],
                        last_pulse_ff[1], last_pulse_ff[0]};

   `SSL_ASSERT_NEXT(a_stall_holds_state, out_valid_ff && !rsp_tready, $stable(cur_ff[0]) && $stable(cur_ff[1]) && $stable(last_pulse_ff[0]) && $stable(last_pulse_ff[1]), "state moved during a stall")
   `SSL_ASSERT_IMPL(a_written_only_on_tick, out_valid_ff && (out_written_ff != '0), out_tick_ff, "pulse written by a set-target item")
   `SSL_ASSERT_NEXT(a_write_changes_pulse, advance && wr[0] && (cfg.pulse_deadband != 8'd0), last_pulse_ff[0] != $past(last_pulse_ff[0]), "pan write left the pulse unchanged")

endmodule

// ===== rtl/servo_slew_limiter_pwm_unit.sv =====
// Top level of the two-channel servo slew limiter with pulse-width output.
// Depends on sslpwm_pkg, sslpwm_front, sslpwm_queue and sslpwm_back.
//
// The block takes one request beat per clock while req_tready is high and returns
// one result beat for each request, in order. A beat goes from the front end into
// a two-entry queue, then through the two back-end stages (slew step, then pulse
// width and result register). With rsp_tready held high the block sustains one
// beat per cycle; the queue holds requests that arrive while a result is stalled,
// until it is full.
// Configuration registers are written through csr_we, csr_index and csr_wdata
// and must only change while no request is in flight.
module servo_slew_limiter_pwm_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sslpwm_pkg::TARGET_W-1:0]      req_tdata,  // [15:0] target_angle
   input  logic [1:0]                           req_tuser,  // [0] action, [1] channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [11:0] pan_pulse, [23:12] tilt_pulse, [24] pan_written, [25] tilt_written,
   // [36:26] pan_angle, [47:37] tilt_angle
   output logic [sslpwm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_we,
   input  logic [sslpwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sslpwm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   sslpwm_pkg::cfg_type cfg_ff, cfg_in;
   sslpwm_pkg::cmd_type push_cmd, head_cmd;
   logic                q_full, q_push, q_pop, q_not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (sslpwm_pkg::csr_index_type'(csr_index))
            sslpwm_pkg::CSR_ANGLE_LIMIT: cfg_in.angle_limit    = csr_wdata[9:0];
            sslpwm_pkg::CSR_STEP_LIMIT:  cfg_in.step_limit     = csr_wdata[9:0];
            sslpwm_pkg::CSR_DEADBAND:    cfg_in.pulse_deadband = csr_wdata[7:0];
            sslpwm_pkg::CSR_CENTER:      cfg_in.pulse_center   = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sslpwm_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sslpwm_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .angle_limit (cfg_ff.angle_limit),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   sslpwm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   sslpwm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_not_empty),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== bench/servo_bench_pkg.sv =====
// Scoreboard of the servo slew limiter bench: predicts every result beat and checks it.
// Depends on sslpwm_pkg for the register index codes and the reset values.
package servo_bench_pkg;
   import sslpwm_pkg::*;

   typedef struct {
      logic [11:0] pan_pulse;
      logic [11:0] tilt_pulse;
      logic        pan_written;
      logic        tilt_written;
      logic [10:0] pan_angle;
      logic [10:0] tilt_angle;
   } servo_status_type;

   class servo_scoreboard;
      int unsigned      failures;
      int               angle_limit;
      int               step_limit;
      int               deadband;
      int               center;
      int               target_angle[2];
      int               current_angle[2];
      int               last_pulse[2];
      servo_status_type expected_status[$];

      function new();
         failures    = 0;
         angle_limit = CFG_RESET.angle_limit;
         step_limit  = CFG_RESET.step_limit;
         deadband    = CFG_RESET.pulse_deadband;
         center      = CFG_RESET.pulse_center;
         for (int ch = 0; ch < 2; ch++) begin
            target_angle[ch]  = 0;
            current_angle[ch] = 0;
            last_pulse[ch]    = PULSE_RESET;
         end
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function void set_register(csr_index_type idx, logic [10:0] value);
         case (idx)
            CSR_ANGLE_LIMIT: angle_limit = value[9:0];
            CSR_STEP_LIMIT:  step_limit  = value[9:0];
            CSR_DEADBAND:    deadband    = value[7:0];
            CSR_CENTER:      center      = value[10:0];
            default: ;
         endcase
      endfunction

      function int limit_magnitude(int value, int bound);
         if (value > bound) return bound;
         if (value < -bound) return -bound;
         return value;
      endfunction

      // Applies one accepted command beat and queues the status it must produce.
      function void note_command(logic tick, logic channel, logic signed [15:0] request);
         servo_status_type status;
         logic [1:0]       wrote;
         int               step;
         int               width;
         int               change;
         wrote = 2'b00;
         if (!tick) begin
            target_angle[channel] = limit_magnitude(int'(request), angle_limit);
         end else begin
            for (int ch = 0; ch < 2; ch++) begin
               step = limit_magnitude(target_angle[ch] - current_angle[ch], step_limit);
               if (step == 0) continue;
               current_angle[ch] += step;
               // Integer division truncates toward zero, as the pulse math requires.
               width = center + current_angle[ch] * 10 / 9;
               if (width < 0) width = 0;
               if (width > 4095) width = 4095;
               change = (width > last_pulse[ch]) ? width - last_pulse[ch]
                                                 : last_pulse[ch] - width;
               if (change < deadband) continue;
               last_pulse[ch] = width;
               wrote[ch]      = 1'b1;
            end
         end
         status.pan_pulse    = 12'(last_pulse[0]);
         status.tilt_pulse   = 12'(last_pulse[1]);
         status.pan_written  = wrote[0];
         status.tilt_written = wrote[1];
         status.pan_angle    = 11'(current_angle[0]);
         status.tilt_angle   = 11'(current_angle[1]);
         expected_status.push_back(status);
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
         failures++;
      endtask

      task check_result(logic [47:0] beat);
         servo_status_type want;
         if (expected_status.size() == 0) begin
            report_mismatch("result beat with nothing outstanding", beat, 0);
            return;
         end
         want = expected_status.pop_front();
         if (beat[11:0] !== want.pan_pulse)
            report_mismatch("pan_pulse", beat[11:0], want.pan_pulse);
         if (beat[23:12] !== want.tilt_pulse)
            report_mismatch("tilt_pulse", beat[23:12], want.tilt_pulse);
         if (beat[24] !== want.pan_written)
            report_mismatch("pan_written", beat[24], want.pan_written);
         if (beat[25] !== want.tilt_written)
            report_mismatch("tilt_written", beat[25], want.tilt_written);
         if (beat[36:26] !== want.pan_angle)
            report_mismatch("pan_angle", $signed(beat[36:26]), $signed(want.pan_angle));
         if (beat[47:37] !== want.tilt_angle)
            report_mismatch("tilt_angle", $signed(beat[47:37]), $signed(want.tilt_angle));
      endtask
   endclass

endpackage

// ===== bench/testbench.sv =====
// Top of the servo slew limiter bench: drives command beats and register writes,
// stalls the result side and checks every result against servo_bench_pkg.
// Depends on sslpwm_pkg, servo_bench_pkg and servo_slew_limiter_pwm_unit.
module testbench;
   import sslpwm_pkg::*;
   import servo_bench_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [15:0]   req_tdata;
   logic [1:0]    req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [47:0]   rsp_tdata;
   logic          csr_we;
   csr_index_type csr_index;
   logic [10:0]   csr_wdata;

   int            ready_pct       = 100;
   bit            use_pattern     = 1'b0;
   logic [7:0]    ready_pattern   = 8'hFF;
   int            hold_off_cycles = 0;

   servo_scoreboard sb = new();

   servo_slew_limiter_pwm_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Result side: a long hold-off wins over the pattern or the random stall.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else if (use_pattern) begin
            rsp_tready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   task automatic send_command(logic tick, logic channel, logic [15:0] angle);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= angle;
      req_tuser  <= {channel, tick};
      do @(posedge clock); while (!req_tready);
      sb.note_command(tick, channel, angle);
   endtask

   task automatic pause_sender(int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      pause_sender(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [10:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(int angle, int step, int band, int mid);
      write_register(CSR_ANGLE_LIMIT, 11'(angle));
      write_register(CSR_STEP_LIMIT, 11'(step));
      write_register(CSR_DEADBAND, 11'(band));
      write_register(CSR_CENTER, 11'(mid));
   endtask

   // Mostly ticks and targets near the legal range; a few targets anywhere in 16 bits.
   task automatic send_random_command();
      int pick;
      int lim;
      int value;
      pick  = $urandom_range(0, 99);
      lim   = sb.angle_limit;
      value = $urandom_range(0, 2 * lim + 100) - lim - 50;
      if (pick < 55) send_command(1'b1, 1'($urandom), 16'($urandom));
      else if (pick < 88) send_command(1'b0, 1'($urandom), 16'(value));
      else send_command(1'b0, 1'($urandom), 16'($urandom));
   endtask

   task automatic run_phase(int items, int max_gap);
      int burst_left;
      burst_left = 0;
      for (int n = 0; n < items; n++) begin
         if (burst_left == 0) begin
            if (max_gap > 0) pause_sender($urandom_range(1, max_gap));
            burst_left = $urandom_range(1, 12);
         end
         send_random_command();
         burst_left--;
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_ANGLE_LIMIT;
      csr_wdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: targets beyond both ends clamp and slew, then pan settles on a near target.
      send_command(1'b0, 1'b0, 16'h7FFF);
      send_command(1'b0, 1'b1, 16'h8000);
      send_command(1'b1, 1'b0, 16'h0000);
      send_command(1'b1, 1'b1, 16'hFFFF);
      send_command(1'b0, 1'b0, 16'd5);
      send_command(1'b1, 1'b0, 16'h0000);
      send_command(1'b1, 1'b0, 16'h0000);
      send_command(1'b1, 1'b0, 16'h0000);
      wait_drained();

      // Unit steps stay under the deadband most of the time.
      write_register(CSR_STEP_LIMIT, 11'd1);
      write_register(CSR_ANGLE_LIMIT, 11'd1023);
      send_command(1'b0, 1'b0, 16'h03FF);
      send_command(1'b0, 1'b1, 16'h7FFF);
      repeat (4) send_command(1'b1, 1'b0, 16'h0000);
      wait_drained();

      // A zero step limit freezes both channels.
      write_register(CSR_STEP_LIMIT, 11'd0);
      send_command(1'b1, 1'b1, 16'hFFFF);
      send_command(1'b1, 1'b0, 16'h0000);
      wait_drained();

      // Zero center with large negative angles drives the width below zero.
      apply_settings(1023, 900, 0, 0);
      send_command(1'b0, 1'b0, 16'h8000);
      send_command(1'b0, 1'b1, 16'(-1000));
      send_command(1'b1, 1'b0, 16'h0000);
      send_command(1'b1, 1'b0, 16'h0000);
      wait_drained();

      apply_settings(0, 900, 255, 2047);
      send_command(1'b0, 1'b0, 16'd500);
      send_command(1'b1, 1'b0, 16'h0000);
      wait_drained();

      // Random phases, one setting each; the first pattern setting covers two phases.
      apply_settings(900, 30, 3, 1500);
      ready_pct = 100;
      run_phase(75, 0);
      wait_drained();

      // The result side holds off while beats keep coming, so the input backs up.
      apply_settings(1023, 900, 0, 2047);
      ready_pct       = 60;
      hold_off_cycles = 80;
      run_phase(75, 0);
      wait_drained();

      apply_settings(900, $urandom_range(1, 5), $urandom_range(0, 4), 1500);
      ready_pattern = 8'($urandom) | 8'h01;
      use_pattern   = 1'b1;
      run_phase(40, 6);
      wait_drained();
      run_phase(35, 6);
      wait_drained();

      apply_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 255), $urandom_range(0, 2047));
      use_pattern = 1'b0;
      ready_pct   = 50;
      run_phase(75, 4);
      wait_drained();

      apply_settings(1023, $urandom_range(1, 60), 0, $urandom_range(0, 300));
      ready_pattern = 8'b1011_0110;
      use_pattern   = 1'b1;
      run_phase(75, 3);
      wait_drained();

      apply_settings($urandom_range(0, 900), $urandom_range(1, 900),
                     $urandom_range(0, 255), $urandom_range(1000, 2000));
      use_pattern = 1'b0;
      ready_pct   = 85;
      run_phase(75, 8);
      wait_drained();

      if (sb.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
